FILE: hw/rtl/rrts_pkg.sv
// Shared package of the round-robin time-slice scheduler.
// Holds request codes, default sizes, the controller/datapath structs and the id reduction table.
// No dependencies.
`default_nettype none

package rrts_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int TASK_IDS_DEF   = 256;

    localparam int ID_IN_W   = 8;
    localparam int START_W   = 33;
    localparam int TICK_W    = 32;
    localparam int QUANT_W   = 16;
    localparam int REQ_W     = 3;
    localparam int COUNT_W   = 9;
    localparam int COUNT_MAX = 511;

    localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd10;

    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PICK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DONE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic push_new;
        logic requeue;
        logic tick;
        logic clear_regs;
        logic pick_keep;
        logic pop;
        logic lookup;
        logic dispatch;
        logic done_read;
        logic done_write;
        logic sweep;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             keep;
        logic             fifo_empty;
        logic             sweep_last;
        logic             out_free;
    } t_stat;

    typedef logic [15:0] t_mod_tab [256];

    // Table of v modulo n for every 8-bit v, built by counting at elaboration.
    function automatic t_mod_tab mod_table(input int n);
        t_mod_tab tab;
        int       c;
        c = 0;
        for (int v = 0; v < 256; v++) begin
            tab[v] = 16'(c);
            if (c + 1 >= n) begin
                c = 0;
            end else begin
                c = c + 1;
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/round_robin_time_slice_scheduler.sv
// Top level of the round-robin time-slice scheduler with a time quantum.
// Depends on rrts_pkg, rrts_ctrl, rrts_dp and rrts_ram.
//
//   Channel   Direction   Handshake            Payload
//   request   in          i_valid / o_stall    i_req_type, i_task_id, i_prior_start,
//                                              i_current_finished
//   result    out         o_valid / i_stall    o_task_valid ... o_task_count
//   config    in          i_cfg_wr_en          i_cfg_wr_data (quantum_length)
//
// One request is in work at a time. Every request passes ST_EXEC and ends in ST_REPLY; done
// adds ST_DONE between them, a dispatching pick adds ST_POP, ST_LOOK and ST_DISP (only ST_POP
// if the FIFO is empty), and clear adds ST_SWEEP. The registered reads of the FIFO RAM and
// the active-table RAM set the longer paths. After reset the active table is cleared one
// entry a cycle, all TASK_IDS entries, while o_stall stays high. A finished result waits in
// the output register while i_stall is high, and the next request is accepted meanwhile.
`default_nettype none

module round_robin_time_slice_scheduler #(
    parameter int FIFO_DEPTH = rrts_pkg::FIFO_DEPTH_DEF,
    parameter int TASK_IDS   = rrts_pkg::TASK_IDS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [rrts_pkg::QUANT_W-1:0]        i_cfg_wr_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [rrts_pkg::REQ_W-1:0]          i_req_type,
    input  wire logic [rrts_pkg::ID_IN_W-1:0]        i_task_id,
    input  wire logic signed [rrts_pkg::START_W-1:0] i_prior_start,
    input  wire logic                                i_current_finished,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_task_valid,
    output logic [rrts_pkg::ID_IN_W-1:0]             o_chosen_id,
    output logic [rrts_pkg::TICK_W-1:0]              o_start_tick,
    output logic [rrts_pkg::TICK_W-1:0]              o_end_tick,
    output logic                                     o_found,
    output logic                                     o_queue_full,
    output logic                                     o_has_tasks,
    output logic [rrts_pkg::COUNT_W-1:0]             o_task_count
);

    rrts_pkg::t_cmd  cmd;
    rrts_pkg::t_stat stat;

    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rrts_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .TASK_IDS   (TASK_IDS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_req_type         (i_req_type),
        .i_task_id          (i_task_id),
        .i_prior_start      (i_prior_start),
        .i_current_finished (i_current_finished),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_task_valid       (o_task_valid),
        .o_chosen_id        (o_chosen_id),
        .o_start_tick       (o_start_tick),
        .o_end_tick         (o_end_tick),
        .o_found            (o_found),
        .o_queue_full       (o_queue_full),
        .o_has_tasks        (o_has_tasks),
        .o_task_count       (o_task_count)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the ready FIFO and the active table. No dependencies.
`default_nettype none

module rrts_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/rrts_ctrl.sv
// Controller state machine of the scheduler: sequences each request through the datapath.
// Depends on rrts_pkg.
`default_nettype none

module rrts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire rrts_pkg::t_stat i_stat,
    output rrts_pkg::t_cmd     o_cmd
);

    typedef enum logic [7:0] {
        ST_SWEEP = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_EXEC  = 8'b0000_0100,
        ST_POP   = 8'b0000_1000,
        ST_LOOK  = 8'b0001_0000,
        ST_DISP  = 8'b0010_0000,
        ST_DONE  = 8'b0100_0000,
        ST_REPLY = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_sweep_reply;
    logic   n_sweep_reply;

    always_comb begin
        n_state       = r_state;
        n_sweep_reply = r_sweep_reply;
        o_cmd         = '0;
        case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = r_sweep_reply ? ST_REPLY : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_stat.req)
                    rrts_pkg::REQ_ADD: begin
                        o_cmd.push_new = 1'b1;
                        n_state        = ST_REPLY;
                    end
                    rrts_pkg::REQ_PICK: begin
                        if (i_stat.keep) begin
                            o_cmd.pick_keep = 1'b1;
                            n_state         = ST_REPLY;
                        end else begin
                            o_cmd.requeue = 1'b1;
                            n_state       = ST_POP;
                        end
                    end
                    rrts_pkg::REQ_DONE: begin
                        o_cmd.done_read = 1'b1;
                        n_state         = ST_DONE;
                    end
                    rrts_pkg::REQ_TICK: begin
                        o_cmd.tick = 1'b1;
                        n_state    = ST_REPLY;
                    end
                    rrts_pkg::REQ_CLEAR: begin
                        o_cmd.clear_regs = 1'b1;
                        n_sweep_reply    = 1'b1;
                        n_state          = ST_SWEEP;
                    end
                    default: begin
                        n_state = ST_REPLY;
                    end
                endcase
            end
            ST_POP: begin
                if (i_stat.fifo_empty) begin
                    n_state = ST_REPLY;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_DISP;
            end
            ST_DISP: begin
                o_cmd.dispatch = 1'b1;
                n_state        = ST_REPLY;
            end
            ST_DONE: begin
                o_cmd.done_write = 1'b1;
                n_state          = ST_REPLY;
            end
            ST_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_sweep_reply  = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SWEEP;
            r_sweep_reply <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_sweep_reply <= n_sweep_reply;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/rrts_dp.sv
// Datapath of the scheduler: ready FIFO, active table, counters and the result register.
// Depends on rrts_pkg and rrts_ram.
`default_nettype none

module rrts_dp #(
    parameter int FIFO_DEPTH = rrts_pkg::FIFO_DEPTH_DEF,
    parameter int TASK_IDS   = rrts_pkg::TASK_IDS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rrts_pkg::t_cmd                i_cmd,
    output rrts_pkg::t_stat                    o_stat,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [rrts_pkg::QUANT_W-1:0]  i_cfg_wr_data,
    input  wire logic [rrts_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [rrts_pkg::ID_IN_W-1:0]  i_task_id,
    input  wire logic signed [rrts_pkg::START_W-1:0] i_prior_start,
    input  wire logic                          i_current_finished,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic                               o_task_valid,
    output logic [rrts_pkg::ID_IN_W-1:0]       o_chosen_id,
    output logic [rrts_pkg::TICK_W-1:0]        o_start_tick,
    output logic [rrts_pkg::TICK_W-1:0]        o_end_tick,
    output logic                               o_found,
    output logic                               o_queue_full,
    output logic                               o_has_tasks,
    output logic [rrts_pkg::COUNT_W-1:0]       o_task_count
);

    localparam int ID_W   = $clog2(TASK_IDS);
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int TOT_W  = $clog2(TASK_IDS + 1);
    localparam int SUM_W0 = ((CNT_W > TOT_W) ? CNT_W : TOT_W) + 1;
    localparam int SUM_W  = (SUM_W0 > 10) ? SUM_W0 : 10;
    localparam int EXT_W  = (ID_W > rrts_pkg::ID_IN_W) ? ID_W : rrts_pkg::ID_IN_W;
    localparam int SW     = rrts_pkg::START_W;
    localparam int FIFO_W = ID_W + SW;
    localparam int ACT_W  = SW + 1;

    localparam rrts_pkg::t_mod_tab MOD_TAB = rrts_pkg::mod_table(TASK_IDS);

    // Control state.
    logic [rrts_pkg::QUANT_W-1:0] r_qlen;
    logic [rrts_pkg::QUANT_W-1:0] r_qleft;
    logic [PTR_W-1:0]             r_head;
    logic [PTR_W-1:0]             r_tail;
    logic [CNT_W-1:0]             r_count;
    logic [TOT_W-1:0]             r_total;
    logic                         r_running;
    logic [ID_W-1:0]              r_run_id;
    logic [rrts_pkg::TICK_W-1:0]  r_tick;
    logic [ID_W-1:0]              r_sweep;
    logic                         r_out_valid;

    // Payload state.
    logic [rrts_pkg::REQ_W-1:0]   r_req;
    logic [ID_W-1:0]              r_id;
    logic [SW-1:0]                r_pstart;
    logic                         r_fin;
    logic [SW-1:0]                r_run_start;
    logic [ID_W-1:0]              r_disp_id;
    logic [SW-1:0]                r_disp_start;
    logic                         r_rs_tv;
    logic [ID_W-1:0]              r_rs_id;
    logic [rrts_pkg::TICK_W-1:0]  r_rs_start;
    logic [rrts_pkg::TICK_W-1:0]  r_rs_end;
    logic                         r_rs_found;
    logic                         r_rs_full;
    logic                         r_o_tv;
    logic [rrts_pkg::ID_IN_W-1:0] r_o_id;
    logic [rrts_pkg::TICK_W-1:0]  r_o_start;
    logic [rrts_pkg::TICK_W-1:0]  r_o_end;
    logic                         r_o_found;
    logic                         r_o_full;
    logic                         r_o_has;
    logic [rrts_pkg::COUNT_W-1:0] r_o_count;

    logic [15:0]       id_mod;
    logic              fifo_full;
    logic              push_req;
    logic              push_ok;
    logic [FIFO_W-1:0] push_data;
    logic [PTR_W-1:0]  head_nxt;
    logic [PTR_W-1:0]  tail_nxt;
    logic [FIFO_W-1:0] fifo_rdata;
    logic [ID_W-1:0]   fifo_tid;
    logic [SW-1:0]     fifo_st;
    logic              act_we;
    logic [ID_W-1:0]   act_waddr;
    logic [ACT_W-1:0]  act_wdata;
    logic [ID_W-1:0]   act_raddr;
    logic [ACT_W-1:0]  act_rdata;
    logic              act_valid;
    logic              out_free;
    logic [SUM_W-1:0]  sum;
    logic [EXT_W-1:0]  rs_id_ext;

    assign id_mod    = MOD_TAB[i_task_id];
    assign fifo_full = (r_count == CNT_W'(FIFO_DEPTH));
    assign push_req  = i_cmd.push_new | (i_cmd.requeue & r_running & ~r_fin);
    assign push_ok   = push_req & ~fifo_full;
    assign push_data = i_cmd.push_new ? {r_id, r_pstart} : {r_run_id, r_run_start};
    assign head_nxt  = (r_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(r_head + 1'b1);
    assign tail_nxt  = (r_tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(r_tail + 1'b1);

    rrts_ram #(
        .W (FIFO_W),
        .D (FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (r_tail),
        .i_wdata (push_data),
        .i_raddr (r_head),
        .o_rdata (fifo_rdata)
    );

    // A head entry with a negative start takes the current tick as its start.
    assign fifo_tid = fifo_rdata[FIFO_W-1:SW];
    assign fifo_st  = fifo_rdata[SW-1] ? {1'b0, r_tick} : fifo_rdata[SW-1:0];

    always_comb begin
        act_we    = 1'b0;
        act_waddr = r_id;
        act_wdata = '0;
        if (i_cmd.sweep) begin
            act_we    = 1'b1;
            act_waddr = r_sweep;
        end else if (i_cmd.dispatch) begin
            act_we    = 1'b1;
            act_waddr = r_disp_id;
            act_wdata = {1'b1, r_disp_start};
        end else if (i_cmd.done_write) begin
            act_we    = act_valid;
            act_waddr = r_id;
        end
    end

    assign act_raddr = i_cmd.lookup ? fifo_tid : r_id;

    rrts_ram #(
        .W (ACT_W),
        .D (TASK_IDS)
    ) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (act_we),
        .i_waddr (act_waddr),
        .i_wdata (act_wdata),
        .i_raddr (act_raddr),
        .o_rdata (act_rdata)
    );

    assign act_valid = act_rdata[SW];
    assign out_free  = ~r_out_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen      <= rrts_pkg::QUANTUM_RST;
            r_qleft     <= rrts_pkg::QUANTUM_RST;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_running   <= 1'b0;
            r_run_id    <= '0;
            r_tick      <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_qlen <= i_cfg_wr_data;
            end
            if (push_ok) begin
                r_tail  <= tail_nxt;
                r_count <= CNT_W'(r_count + 1'b1);
            end
            if (i_cmd.pop) begin
                r_head  <= head_nxt;
                r_count <= CNT_W'(r_count - 1'b1);
            end
            if (i_cmd.tick) begin
                r_tick <= r_tick + 1'b1;
                if (r_qleft != '0) begin
                    r_qleft <= r_qleft - 1'b1;
                end
            end
            if (i_cmd.requeue || i_cmd.done_read) begin
                r_running <= 1'b0;
            end
            if (i_cmd.dispatch) begin
                r_running <= 1'b1;
                r_run_id  <= r_disp_id;
                r_qleft   <= r_qlen;
                if (!act_valid) begin
                    r_total <= TOT_W'(r_total + 1'b1);
                end
            end
            if (i_cmd.done_write && act_valid) begin
                r_total <= TOT_W'(r_total - 1'b1);
            end
            if (i_cmd.sweep) begin
                r_sweep <= (r_sweep == ID_W'(TASK_IDS - 1)) ? '0 : ID_W'(r_sweep + 1'b1);
            end
            if (i_cmd.clear_regs) begin
                r_head    <= '0;
                r_tail    <= '0;
                r_count   <= '0;
                r_total   <= '0;
                r_running <= 1'b0;
                r_run_id  <= '0;
                r_tick    <= '0;
                r_qleft   <= r_qlen;
                r_sweep   <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req      <= i_req_type;
            r_id       <= id_mod[ID_W-1:0];
            r_pstart   <= i_prior_start;
            r_fin      <= i_current_finished;
            r_rs_tv    <= 1'b0;
            r_rs_id    <= '0;
            r_rs_start <= '0;
            r_rs_end   <= '0;
            r_rs_found <= 1'b0;
            r_rs_full  <= 1'b0;
        end
        if (push_req && fifo_full) begin
            r_rs_full <= 1'b1;
        end
        if (i_cmd.pick_keep) begin
            r_rs_tv    <= 1'b1;
            r_rs_id    <= r_run_id;
            r_rs_start <= r_run_start[rrts_pkg::TICK_W-1:0];
        end
        if (i_cmd.lookup) begin
            r_disp_id    <= fifo_tid;
            r_disp_start <= fifo_st;
        end
        if (i_cmd.dispatch) begin
            r_run_start <= r_disp_start;
            r_rs_tv     <= 1'b1;
            r_rs_id     <= r_disp_id;
            r_rs_start  <= r_disp_start[rrts_pkg::TICK_W-1:0];
        end
        if (i_cmd.done_write && act_valid) begin
            r_rs_found <= 1'b1;
            r_rs_end   <= r_tick;
        end
        if (i_cmd.load_out) begin
            r_o_tv    <= r_rs_tv;
            r_o_id    <= rs_id_ext[rrts_pkg::ID_IN_W-1:0];
            r_o_start <= r_rs_start;
            r_o_end   <= r_rs_end;
            r_o_found <= r_rs_found;
            r_o_full  <= r_rs_full;
            r_o_has   <= (sum != '0);
            r_o_count <= (sum > SUM_W'(rrts_pkg::COUNT_MAX)) ?
                         rrts_pkg::COUNT_W'(rrts_pkg::COUNT_MAX) :
                         sum[rrts_pkg::COUNT_W-1:0];
        end
    end

    assign sum       = SUM_W'(r_count) + SUM_W'(r_total);
    assign rs_id_ext = EXT_W'(r_rs_id);

    assign o_stat.req        = r_req;
    assign o_stat.keep       = r_running & ~r_fin & (r_qleft != '0);
    assign o_stat.fifo_empty = (r_count == '0);
    assign o_stat.sweep_last = (r_sweep == ID_W'(TASK_IDS - 1));
    assign o_stat.out_free   = out_free;

    assign o_valid      = r_out_valid;
    assign o_task_valid = r_o_tv;
    assign o_chosen_id  = r_o_id;
    assign o_start_tick = r_o_start;
    assign o_end_tick   = r_o_end;
    assign o_found      = r_o_found;
    assign o_queue_full = r_o_full;
    assign o_has_tasks  = r_o_has;
    assign o_task_count = r_o_count;

endmodule

`default_nettype wire

FILE: hw/rtl/rrts_chk.sv
// Port-level checker of the scheduler, attached to the top level by a bind statement.
// Depends on rrts_pkg and round_robin_time_slice_scheduler.
`default_nettype none

module rrts_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic                          o_task_valid,
    input wire logic [rrts_pkg::ID_IN_W-1:0]  o_chosen_id,
    input wire logic [rrts_pkg::TICK_W-1:0]   o_start_tick,
    input wire logic [rrts_pkg::TICK_W-1:0]   o_end_tick,
    input wire logic                          o_found,
    input wire logic                          o_has_tasks,
    input wire logic [rrts_pkg::COUNT_W-1:0]  o_task_count
);

    // A stalled result transfer stays valid and keeps its id, start and end ticks and task count.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_chosen_id) && $stable(o_start_tick)
            && $stable(o_end_tick) && $stable(o_task_count))
        else $error("stalled result changed");

    // Only a pick reports a task and only a done reports a found entry.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_task_valid && o_found))
        else $error("pick and done fields both set");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_has_tasks == (o_task_count != '0)))
        else $error("has_tasks disagrees with task_count");

    a_no_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_task_valid |-> (o_chosen_id == '0) && (o_start_tick == '0))
        else $error("task fields set without a task");

    a_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_end_tick == '0))
        else $error("end tick set without a found entry");

endmodule

bind round_robin_time_slice_scheduler rrts_chk u_rrts_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_task_valid (o_task_valid),
    .o_chosen_id  (o_chosen_id),
    .o_start_tick (o_start_tick),
    .o_end_tick   (o_end_tick),
    .o_found      (o_found),
    .o_has_tasks  (o_has_tasks),
    .o_task_count (o_task_count)
);

`default_nettype wire

FILE: tb/round_robin_time_slice_scheduler_tb.sv
// Self-checking testbench for the round-robin time-slice scheduler.
// Depends on rrts_pkg and round_robin_time_slice_scheduler; predicts every result in-bench.
`timescale 1ns / 100ps

module round_robin_time_slice_scheduler_tb;

    localparam int FIFO_DEPTH  = rrts_pkg::FIFO_DEPTH_DEF;
    localparam int TASK_IDS    = rrts_pkg::TASK_IDS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = TASK_IDS + 16;

    localparam logic [rrts_pkg::REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [rrts_pkg::REQ_W-1:0] REQ_UNUSED_LAST  = {rrts_pkg::REQ_W{1'b1}};
    localparam logic signed [rrts_pkg::START_W-1:0] NEVER_STARTED = -33'sd1;

    typedef struct packed {
        logic [rrts_pkg::REQ_W-1:0]          req;
        logic [rrts_pkg::ID_IN_W-1:0]        id;
        logic signed [rrts_pkg::START_W-1:0] pstart;
        logic                                fin;
    } t_sched_req;

    typedef struct packed {
        logic                         task_valid;
        logic [rrts_pkg::ID_IN_W-1:0] chosen_id;
        logic [rrts_pkg::TICK_W-1:0]  start_tick;
        logic [rrts_pkg::TICK_W-1:0]  end_tick;
        logic                         found;
        logic                         queue_full;
        logic                         has_tasks;
        logic [rrts_pkg::COUNT_W-1:0] task_count;
    } t_sched_res;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_wr_en = 1'b0;
    logic [rrts_pkg::QUANT_W-1:0]        i_cfg_wr_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic [rrts_pkg::REQ_W-1:0]          i_req_type = '0;
    logic [rrts_pkg::ID_IN_W-1:0]        i_task_id = '0;
    logic signed [rrts_pkg::START_W-1:0] i_prior_start = '0;
    logic                                i_current_finished = 1'b0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic                                o_task_valid;
    logic [rrts_pkg::ID_IN_W-1:0]        o_chosen_id;
    logic [rrts_pkg::TICK_W-1:0]         o_start_tick;
    logic [rrts_pkg::TICK_W-1:0]         o_end_tick;
    logic                                o_found;
    logic                                o_queue_full;
    logic                                o_has_tasks;
    logic [rrts_pkg::COUNT_W-1:0]        o_task_count;

    round_robin_time_slice_scheduler #(
        .FIFO_DEPTH(FIFO_DEPTH),
        .TASK_IDS  (TASK_IDS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_task_id         (i_task_id),
        .i_prior_start     (i_prior_start),
        .i_current_finished(i_current_finished),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_task_valid      (o_task_valid),
        .o_chosen_id       (o_chosen_id),
        .o_start_tick      (o_start_tick),
        .o_end_tick        (o_end_tick),
        .o_found           (o_found),
        .o_queue_full      (o_queue_full),
        .o_has_tasks       (o_has_tasks),
        .o_task_count      (o_task_count)
    );

    always #10 i_clk = ~i_clk;

    // Scheduler state as the testbench tracks it.
    logic [rrts_pkg::ID_IN_W-1:0] ready_id    [FIFO_DEPTH];
    logic [rrts_pkg::START_W-1:0] ready_start [FIFO_DEPTH];
    int unsigned                  ready_head, ready_tail, ready_count;
    bit                           table_valid [TASK_IDS];
    logic [rrts_pkg::START_W-1:0] table_start [TASK_IDS];
    int unsigned                  table_total;
    bit                           run_valid;
    logic [rrts_pkg::ID_IN_W-1:0] run_id;
    logic [rrts_pkg::QUANT_W-1:0] slice_left;
    logic [rrts_pkg::TICK_W-1:0]  ticks;
    logic [rrts_pkg::QUANT_W-1:0] quantum = rrts_pkg::QUANTUM_RST;

    t_sched_res  pending_results[$];
    int          mismatch_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int unsigned cycle_count = 0;

    function automatic void clear_schedule();
        foreach (table_valid[k]) table_valid[k] = 1'b0;
        ready_head  = 0;
        ready_tail  = 0;
        ready_count = 0;
        table_total = 0;
        run_valid   = 1'b0;
        run_id      = '0;
        ticks       = '0;
        slice_left  = quantum;
    endfunction

    function automatic bit ready_push(input logic [rrts_pkg::ID_IN_W-1:0] id,
                                      input logic [rrts_pkg::START_W-1:0] st);
        if (ready_count >= FIFO_DEPTH) return 1'b0;
        ready_id[ready_tail]    = id;
        ready_start[ready_tail] = st;
        ready_tail              = (ready_tail + 1) % FIFO_DEPTH;
        ready_count++;
        return 1'b1;
    endfunction

    function automatic t_sched_res schedule_step(input t_sched_req rq);
        t_sched_res                   r;
        int                           idx;
        int                           tid;
        logic [rrts_pkg::START_W-1:0] st;
        int unsigned                  total;
        r   = '0;
        idx = int'(rq.id) % TASK_IDS;
        case (rq.req)
            rrts_pkg::REQ_ADD: begin
                if (!ready_push(rq.id, rq.pstart)) r.queue_full = 1'b1;
            end
            rrts_pkg::REQ_PICK: begin
                if (run_valid && !rq.fin && slice_left > 0) begin
                    r.task_valid = 1'b1;
                    r.chosen_id  = run_id;
                    r.start_tick = table_start[run_id][rrts_pkg::TICK_W-1:0];
                end else begin
                    // A preempted task goes back to the tail; if that fails it stays active.
                    if (run_valid && !rq.fin) begin
                        if (!ready_push(run_id, table_start[run_id])) r.queue_full = 1'b1;
                    end
                    run_valid = 1'b0;
                    if (ready_count > 0) begin
                        tid         = int'(ready_id[ready_head]) % TASK_IDS;
                        st          = ready_start[ready_head];
                        ready_head  = (ready_head + 1) % FIFO_DEPTH;
                        ready_count--;
                        if (st[rrts_pkg::START_W-1]) st = {1'b0, ticks};
                        if (!table_valid[tid]) begin
                            table_valid[tid] = 1'b1;
                            table_total++;
                        end
                        table_start[tid] = st;
                        run_valid    = 1'b1;
                        run_id       = rrts_pkg::ID_IN_W'(tid);
                        slice_left   = quantum;
                        r.task_valid = 1'b1;
                        r.chosen_id  = rrts_pkg::ID_IN_W'(tid);
                        r.start_tick = st[rrts_pkg::TICK_W-1:0];
                    end
                end
            end
            rrts_pkg::REQ_DONE: begin
                if (table_valid[idx]) begin
                    r.end_tick       = ticks;
                    r.found          = 1'b1;
                    table_valid[idx] = 1'b0;
                    table_total--;
                end
                run_valid = 1'b0;
            end
            rrts_pkg::REQ_TICK: begin
                ticks = ticks + 1'b1;
                if (slice_left > 0) slice_left = slice_left - 1'b1;
            end
            rrts_pkg::REQ_CLEAR: begin
                clear_schedule();
            end
            default: begin
            end
        endcase
        total        = ready_count + table_total;
        r.has_tasks  = (total > 0);
        r.task_count = (total > rrts_pkg::COUNT_MAX) ?
                       rrts_pkg::COUNT_W'(rrts_pkg::COUNT_MAX) : rrts_pkg::COUNT_W'(total);
        return r;
    endfunction

    function automatic t_sched_req make_req(input logic [rrts_pkg::REQ_W-1:0] req,
                                            input logic [rrts_pkg::ID_IN_W-1:0] id,
                                            input logic signed [rrts_pkg::START_W-1:0] pstart,
                                            input logic fin);
        t_sched_req rq;
        rq.req    = req;
        rq.id     = id;
        rq.pstart = pstart;
        rq.fin    = fin;
        return rq;
    endfunction

    // Ids mostly come from a small pool so that done requests find their tasks.
    function automatic logic [rrts_pkg::ID_IN_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 65) return rrts_pkg::ID_IN_W'($urandom_range(0, 15));
        return rrts_pkg::ID_IN_W'($urandom_range(0, 255));
    endfunction

    function automatic logic signed [rrts_pkg::START_W-1:0] pick_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return NEVER_STARTED;
        if (r < 60) return {1'b1, 32'($urandom)};
        return {1'b0, 32'($urandom)};
    endfunction

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_res ex;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                mismatch_count++;
            end else begin
                ex = pending_results.pop_front();
                check_field("task_valid", ex.task_valid, o_task_valid);
                check_field("chosen_id", ex.chosen_id, o_chosen_id);
                check_field("start_tick", ex.start_tick, o_start_tick);
                check_field("end_tick", ex.end_tick, o_end_tick);
                check_field("found", ex.found, o_found);
                check_field("queue_full", ex.queue_full, o_queue_full);
                check_field("has_tasks", ex.has_tasks, o_has_tasks);
                check_field("task_count", ex.task_count, o_task_count);
            end
        end
    end

    // Called and returns at a falling edge; valid stays high after the transfer so that a
    // following request can take over with no gap in i_valid.
    task automatic send_req(input t_sched_req rq);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_req_type         <= rq.req;
        i_task_id          <= rq.id;
        i_prior_start      <= rq.pstart;
        i_current_finished <= rq.fin;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!o_stall) begin
                taken = 1'b1;
                pending_results.push_back(schedule_step(rq));
            end
            @(negedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_quantum(input logic [rrts_pkg::QUANT_W-1:0] value);
        wait_all_results();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_wr_data <= value;
        i_cfg_wr_en   <= 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        quantum = value;
    endtask

    task automatic test_pick_and_done();
        send_req(make_req(rrts_pkg::REQ_PICK, 8'd0, '0, 1'b0));
        send_req(make_req(rrts_pkg::REQ_ADD, 8'd255, NEVER_STARTED, 1'b0));
        send_req(make_req(rrts_pkg::REQ_ADD, 8'd0, 33'h0_FFFF_FFFF, 1'b0));
        send_req(make_req(rrts_pkg::REQ_TICK, 8'd0, '0, 1'b0));
        send_req(make_req(rrts_pkg::REQ_PICK, 8'd0, '0, 1'b0));
        send_req(make_req(rrts_pkg::REQ_PICK, 8'd0, '0, 1'b0));
        // The finished task is not requeued but stays in the active table.
        send_req(make_req(rrts_pkg::REQ_PICK, 8'd0, '0, 1'b1));
        send_req(make_req(rrts_pkg::REQ_DONE, 8'd255, '0, 1'b0));
        send_req(make_req(rrts_pkg::REQ_DONE, 8'd200, '0, 1'b0));
        for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++) begin
            send_req(make_req(rrts_pkg::REQ_W'(c), 8'hFF, NEVER_STARTED, 1'b1));
        end
        send_req(make_req(rrts_pkg::REQ_CLEAR, 8'd0, '0, 1'b0));
    endtask

    task automatic test_zero_quantum();
        set_quantum('0);
        send_req(make_req(rrts_pkg::REQ_ADD, 8'd3, 33'sh1_0000_0000, 1'b0));
        send_req(make_req(rrts_pkg::REQ_ADD, 8'd4, 33'sd12345, 1'b0));
        send_req(make_req(rrts_pkg::REQ_PICK, 8'd0, '0, 1'b0));
        send_req(make_req(rrts_pkg::REQ_PICK, 8'd0, '0, 1'b0));
        send_req(make_req(rrts_pkg::REQ_TICK, 8'd0, '0, 1'b0));
        send_req(make_req(rrts_pkg::REQ_PICK, 8'd0, '0, 1'b0));
        send_req(make_req(rrts_pkg::REQ_DONE, 8'd3, '0, 1'b0));
        send_req(make_req(rrts_pkg::REQ_CLEAR, 8'd0, '0, 1'b0));
    endtask

    // Fills the FIFO past its depth, then makes a preempted task's requeue fail.
    task automatic test_fifo_overflow(input logic [rrts_pkg::QUANT_W-1:0] q_len);
        set_quantum(q_len);
        send_req(make_req(rrts_pkg::REQ_CLEAR, pick_id(), pick_start(), 1'b0));
        repeat (FIFO_DEPTH + 1) begin
            send_req(make_req(rrts_pkg::REQ_ADD, pick_id(), pick_start(), 1'b0));
        end
        send_req(make_req(rrts_pkg::REQ_PICK, pick_id(), pick_start(), 1'b0));
        send_req(make_req(rrts_pkg::REQ_ADD, pick_id(), pick_start(), 1'b0));
        repeat (q_len) send_req(make_req(rrts_pkg::REQ_TICK, pick_id(), pick_start(), 1'b1));
        send_req(make_req(rrts_pkg::REQ_PICK, pick_id(), pick_start(), 1'b0));
    endtask

    task automatic test_random_traffic(input logic [rrts_pkg::QUANT_W-1:0] q_len,
                                       input int n_items);
        t_sched_req rq;
        int         r;
        set_quantum(q_len);
        for (int k = 0; k < n_items; k++) begin
            r  = $urandom_range(0, 99);
            rq = make_req(rrts_pkg::REQ_ADD, pick_id(), pick_start(),
                          ($urandom_range(0, 3) == 0));
            if (r < 28) begin
                rq.req = rrts_pkg::REQ_ADD;
            end else if (r < 54) begin
                rq.req = rrts_pkg::REQ_PICK;
            end else if (r < 78) begin
                rq.req = rrts_pkg::REQ_TICK;
            end else if (r < 93) begin
                rq.req = rrts_pkg::REQ_DONE;
                if (run_valid && $urandom_range(0, 1)) rq.id = run_id;
            end else if (r < 95) begin
                rq.req = rrts_pkg::REQ_CLEAR;
            end else begin
                rq.req = rrts_pkg::REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
            end
            send_req(rq);
            if ($urandom_range(0, 79) == 0) wait_all_results();
        end
    endtask

    initial begin
        clear_schedule();
        tx_idle_pct = 13;
        rx_idle_pct = 82;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_pick_and_done();
        test_zero_quantum();
        test_fifo_overflow(16'd1);
        test_random_traffic(16'hFFFF, 180);
        test_random_traffic(16'd1, 180);

        wait_all_results();
        tx_idle_pct = 82;
        rx_idle_pct = 13;
        test_random_traffic(16'd3, 180);
        test_fifo_overflow(16'd3);
        test_random_traffic(rrts_pkg::QUANTUM_RST, 180);

        wait_all_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(rrts_pkg::QUANT_W'($urandom_range(1, 8)), 180);
        test_random_traffic(rrts_pkg::QUANT_W'($urandom_range(1, 65535)), 180);

        wait_all_results();
        repeat (SETTLE) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
